### hw/rtl/pva_pkg.sv
// shared widths, codes and types of the voice allocator
`timescale 1ns / 1ps

package pva_pkg;

   localparam int CHANNEL_COUNT_DEF = 64;
   localparam int NOTE_COUNT_DEF    = 120;

   localparam int OP_W    = 2;
   localparam int NOTE_W  = 7;
   localparam int VOL_W   = 8;
   localparam int INSTR_W = 8;
   localparam int CH_W    = 6;

   localparam logic [OP_W-1:0] OP_PRESS       = 2'd0;
   localparam logic [OP_W-1:0] OP_RELEASE     = 2'd1;
   localparam logic [OP_W-1:0] OP_RELEASE_ALL = 2'd2;

   // command broadcast to every channel cell
   typedef struct packed {
      logic              claim;      // top-most free cell (or cell 0 when full) takes note
      logic              free_sel;   // lowest selected busy cell is freed
      logic              match_note; // busy cells only count when their note matches
      logic [NOTE_W-1:0] note;
   } pva_cmd_type;

   // ascending search chain, low channel to high
   typedef struct packed {
      logic found;
      logic found2;
   } pva_chain_type;

endpackage

### hw/rtl/pva_cell.sv
// one channel cell: busy flag, owning note and its links in both search chains
`timescale 1ns / 1ps

module pva_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  pva_pkg::pva_cmd_type            cmd,
   input  pva_pkg::pva_chain_type          up_in,
   output pva_pkg::pva_chain_type          up_out,
   input  logic                            down_in,
   output logic                            down_out,
   input  logic                            force_take,
   output logic                            take_up,
   output logic                            take_down,
   output logic [pva_pkg::NOTE_W-1:0]      note_out
);

   logic                       busy_ff;
   logic                       busy_in;
   logic [pva_pkg::NOTE_W-1:0] note_ff;
   logic [pva_pkg::NOTE_W-1:0] note_in;
   logic                       cand_up;
   logic                       cand_down;
   logic                       claim_here;

   assign cand_up   = busy_ff && (!cmd.match_note || (note_ff == cmd.note));
   assign take_up   = cand_up && !up_in.found;
   assign up_out.found  = up_in.found | cand_up;
   // a second hit further up tells whether more busy cells follow
   assign up_out.found2 = up_in.found2 | (up_in.found & cand_up);

   assign cand_down = !busy_ff;
   assign take_down = cand_down && !down_in;
   assign down_out  = down_in | cand_down;

   assign claim_here = cmd.claim && (take_down || force_take);
   assign note_out   = note_ff;

   always_comb begin
      busy_in = busy_ff;
      note_in = note_ff;
      if (claim_here) begin
         busy_in = 1'b1;
         note_in = cmd.note;
      end else if (cmd.free_sel && take_up) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      note_ff <= note_in;
   end

endmodule

### hw/rtl/polyphonic_voice_allocator_top.sv
// voice allocator top level: key map, control sequencer and the row of channel cells
`timescale 1ns / 1ps

// Takes key events on start/busy and emits note-on and note-off events on a
// one-cycle rsp_strobe; the receiver cannot stall, so every result must be
// taken in the cycle it is shown. A key press or release is handled in the
// transfer cycle and one pass through the row of channel cells, whose search
// chains find the highest free channel or the lowest channel holding the note.
// The result is shown in the cycle after that pass, while the next transfer
// may already be taken. Release-all gives one note-off per cycle in ascending
// channel order while the key map is cleared one note per cycle; busy stays
// high until both are done. After reset busy stays high while the key map
// is cleared.
// The instrument register may only be written while busy is low.
module polyphonic_voice_allocator_top #(
   parameter int CHANNEL_COUNT = pva_pkg::CHANNEL_COUNT_DEF,
   parameter int NOTE_COUNT    = pva_pkg::NOTE_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [pva_pkg::OP_W-1:0]        req_operation,
   input  logic [pva_pkg::NOTE_W-1:0]      req_key_note,
   input  logic [pva_pkg::VOL_W-1:0]       req_key_volume,
   output logic                            rsp_strobe,
   output logic [pva_pkg::CH_W-1:0]        rsp_channel,
   output logic [pva_pkg::NOTE_W-1:0]      rsp_note_number,
   output logic                            rsp_is_note_off,
   output logic [pva_pkg::VOL_W-1:0]       rsp_volume,
   output logic [pva_pkg::INSTR_W-1:0]     rsp_instrument,
   output logic                            rsp_last,
   input  logic                            csr_wr_en,
   input  logic [pva_pkg::INSTR_W-1:0]     csr_wr_data
);

   localparam int NOTE_IDX_W = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_EXEC  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]                     state_ff;
   logic [1:0]                     state_in;
   logic [pva_pkg::OP_W-1:0]       op_ff;
   logic [pva_pkg::NOTE_W-1:0]     note_ff;
   logic [pva_pkg::VOL_W-1:0]      vol_ff;
   logic [pva_pkg::INSTR_W-1:0]    instrument_ff;

   logic                           held_mem [NOTE_COUNT];
   logic                           held_rd_ff;
   logic                           held_we;
   logic [NOTE_IDX_W-1:0]          held_waddr;
   logic                           held_wdata;
   logic                           clr_busy_ff;
   logic                           clr_busy_in;
   logic [NOTE_IDX_W-1:0]          clr_idx_ff;
   logic [NOTE_IDX_W-1:0]          clr_idx_in;

   logic                           rsp_strobe_ff;
   logic                           rsp_strobe_in;
   logic [pva_pkg::CH_W-1:0]       rsp_channel_ff;
   logic [pva_pkg::CH_W-1:0]       rsp_channel_in;
   logic [pva_pkg::NOTE_W-1:0]     rsp_note_ff;
   logic [pva_pkg::NOTE_W-1:0]     rsp_note_in;
   logic                           rsp_off_ff;
   logic                           rsp_off_in;
   logic [pva_pkg::VOL_W-1:0]      rsp_volume_ff;
   logic [pva_pkg::VOL_W-1:0]      rsp_volume_in;
   logic [pva_pkg::INSTR_W-1:0]    rsp_instr_ff;
   logic [pva_pkg::INSTR_W-1:0]    rsp_instr_in;
   logic                           rsp_last_ff;
   logic                           rsp_last_in;

   logic                           accept;
   logic                           in_range;
   logic                           exec;
   logic                           drain_act;
   logic                           press_act;
   logic                           release_act;
   logic                           none_free;
   pva_pkg::pva_cmd_type           cmd;

   pva_pkg::pva_chain_type         up_chain [CHANNEL_COUNT+1];
   logic [CHANNEL_COUNT:0]         down_found;
   logic [CHANNEL_COUNT-1:0]       take_up;
   logic [CHANNEL_COUNT-1:0]       take_down;
   logic [pva_pkg::NOTE_W-1:0]     cell_note [CHANNEL_COUNT];
   logic [pva_pkg::CH_W-1:0]       up_idx;
   logic [pva_pkg::CH_W-1:0]       down_idx;
   logic [pva_pkg::NOTE_W-1:0]     up_note;

   assign busy   = (state_ff != ST_IDLE) || clr_busy_ff;
   assign accept = start && !busy;
   assign exec   = (state_ff == ST_EXEC);

   assign in_range    = ({1'b0, note_ff} < (pva_pkg::NOTE_W+1)'(NOTE_COUNT));
   assign press_act   = exec && (op_ff == pva_pkg::OP_PRESS) && in_range && !held_rd_ff;
   assign release_act = exec && (op_ff == pva_pkg::OP_RELEASE) && in_range;
   assign drain_act   = (exec && (op_ff == pva_pkg::OP_RELEASE_ALL)) ||
                        (state_ff == ST_DRAIN);

   always_comb begin
      cmd.claim      = press_act;
      cmd.free_sel   = release_act || drain_act;
      cmd.match_note = release_act;
      cmd.note       = note_ff;
   end

   // chain ends
   assign up_chain[0]               = '0;
   assign down_found[CHANNEL_COUNT] = 1'b0;
   assign none_free                 = !down_found[0];

   for (genvar i = 0; i < CHANNEL_COUNT; i++) begin : g_cell
      pva_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .up_in      (up_chain[i]),
         .up_out     (up_chain[i+1]),
         .down_in    (down_found[i+1]),
         .down_out   (down_found[i]),
         .force_take ((i == 0) ? none_free : 1'b0),
         .take_up    (take_up[i]),
         .take_down  (take_down[i]),
         .note_out   (cell_note[i])
      );
   end

   // one-hot selections to channel number and note
   always_comb begin
      up_idx   = '0;
      down_idx = '0;
      up_note  = '0;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
         if (take_up[i]) begin
            up_idx  = up_idx | pva_pkg::CH_W'(i);
            up_note = up_note | cell_note[i];
         end
         if (take_down[i]) begin
            down_idx = down_idx | pva_pkg::CH_W'(i);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (drain_act && up_chain[CHANNEL_COUNT].found2) begin
               state_in = ST_DRAIN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DRAIN: begin
            if (!up_chain[CHANNEL_COUNT].found2) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // key map clearing pass, one note per cycle, after reset and on release-all
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_idx_in  = clr_idx_ff;
      if (clr_busy_ff) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (clr_idx_ff == NOTE_IDX_W'(NOTE_COUNT - 1)) begin
            clr_busy_in = 1'b0;
            clr_idx_in  = '0;
         end
      end else if (exec && (op_ff == pva_pkg::OP_RELEASE_ALL)) begin
         clr_busy_in = 1'b1;
         clr_idx_in  = '0;
      end
   end

   always_comb begin
      held_we    = 1'b0;
      held_waddr = note_ff[NOTE_IDX_W-1:0];
      held_wdata = 1'b0;
      if (clr_busy_ff) begin
         held_we    = 1'b1;
         held_waddr = clr_idx_ff;
      end else if (press_act) begin
         held_we    = 1'b1;
         held_wdata = 1'b1;
      end else if (release_act) begin
         held_we    = 1'b1;
      end
   end

   always_comb begin
      rsp_strobe_in  = 1'b0;
      rsp_channel_in = up_idx;
      rsp_note_in    = up_note;
      rsp_off_in     = 1'b1;
      rsp_volume_in  = '0;
      rsp_instr_in   = '0;
      rsp_last_in    = 1'b1;
      if (press_act) begin
         rsp_strobe_in  = 1'b1;
         rsp_channel_in = down_idx;
         rsp_note_in    = note_ff;
         rsp_off_in     = 1'b0;
         rsp_volume_in  = vol_ff;
         rsp_instr_in   = instrument_ff;
      end else if (release_act) begin
         rsp_strobe_in = up_chain[CHANNEL_COUNT].found;
      end else if (drain_act) begin
         rsp_strobe_in = up_chain[CHANNEL_COUNT].found;
         rsp_last_in   = !up_chain[CHANNEL_COUNT].found2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         clr_busy_ff   <= 1'b1;
         clr_idx_ff    <= '0;
         instrument_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_busy_ff   <= clr_busy_in;
         clr_idx_ff    <= clr_idx_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_wr_en) begin
            instrument_ff <= csr_wr_data;
         end
      end
   end

   // the held mark is read at the transfer and used in the following cycle
   always_ff @(posedge clock) begin
      if (held_we) begin
         held_mem[held_waddr] <= held_wdata;
      end
      if (accept) begin
         held_rd_ff <= held_mem[req_key_note[NOTE_IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_operation;
         note_ff <= req_key_note;
         vol_ff  <= req_key_volume;
      end
      rsp_channel_ff <= rsp_channel_in;
      rsp_note_ff    <= rsp_note_in;
      rsp_off_ff     <= rsp_off_in;
      rsp_volume_ff  <= rsp_volume_in;
      rsp_instr_ff   <= rsp_instr_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_channel     = rsp_channel_ff;
   assign rsp_note_number = rsp_note_ff;
   assign rsp_is_note_off = rsp_off_ff;
   assign rsp_volume      = rsp_volume_ff;
   assign rsp_instrument  = rsp_instr_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
